@@ sv/tcce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // field widths on the channels
  localparam int CMD_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int ROW_OUT_W   = 5;
  localparam int COL_OUT_W   = 7;
  localparam int CELL_W      = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int LAST_ROW_W  = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT_CHAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_POS  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_COLOR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SCROLL   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAST_ROW = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 4'd1;

  // register and state reset values
  localparam logic [LAST_ROW_W-1:0] LAST_ROW_RST = 5'd24;
  localparam logic [CFG_DATA_W-1:0] COLUMNS_RST  = 8'd80;
  localparam logic [BYTE_W-1:0]     ATTR_RST     = 8'd7;

  // special characters
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_BLANK = 8'h20;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    OP_CR,
    OP_LF,
    OP_TAB,
    OP_CHAR,
    OP_SETPOS,
    OP_COLOR,
    OP_CLEAR,
    OP_SCROLL,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] row;
    logic [BYTE_W-1:0] col;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SYNC,
    ST_SCROLL,
    ST_BLANK,
    ST_READ,
    ST_RESP
  } state_t;

endpackage

@@ sv/tcce_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce channel interfaces
// Command channel and result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcce_in_if;
  logic                             valid;
  logic                             ready;
  logic [tcce_pkg::CMD_W-1:0]       command;
  logic [tcce_pkg::BYTE_W-1:0]      char_code;
  logic [tcce_pkg::BYTE_W-1:0]      row;
  logic [tcce_pkg::BYTE_W-1:0]      col;
  logic [tcce_pkg::BYTE_W-1:0]      color;

  modport source (output valid, command, char_code, row, col, color, input ready);
  modport sink   (input valid, command, char_code, row, col, color, output ready);
endinterface

interface tcce_out_if;
  logic                             valid;
  logic                             ready;
  logic [tcce_pkg::ROW_OUT_W-1:0]   cursor_row;
  logic [tcce_pkg::COL_OUT_W-1:0]   cursor_col;
  logic [tcce_pkg::CELL_W-1:0]      cell_value;
  logic [tcce_pkg::BYTE_W-1:0]      previous_color;

  modport source (output valid, cursor_row, cursor_col, cell_value, previous_color,
                  input ready);
  modport sink   (input valid, cursor_row, cursor_col, cell_value, previous_color,
                  output ready);
endinterface

@@ sv/text_console_cursor_engine_top.sv @@
`timescale 1ns / 1ps
// put_char, set_position, set_color and unknown commands: execute step, then result register;
//   read_cell: execute step, store read, then result register
// clear: blanks (last_row+1)*columns cells; scroll, and a line feed or wrap on the bottom
//   row: rows move up, then the bottom row is blanked, one store write per cycle
// the back end takes one item at a time (execute and result steps); a 2-entry queue ahead
// accepts more; reset: cursor home, attribute 7, geometry 25x80; the screen store is not cleared
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Text console engine: configuration registers, command front, queue and
// execution back end with the screen store.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tcce_in_if.sink                             in_ch,
  tcce_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LAST_ROW_W = tcce_pkg::LAST_ROW_W;
  localparam int CFG_DATA_W = tcce_pkg::CFG_DATA_W;

  logic [LAST_ROW_W-1:0] last_row_r;
  logic [CFG_DATA_W-1:0] columns_r;
  logic [ROW_W-1:0]      lr;
  logic [COL_W-1:0]      cols_m1;

  logic           push, pop, can_push, head_valid;
  tcce_pkg::cmd_t push_cmd, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_row_r <= tcce_pkg::LAST_ROW_RST;
      columns_r  <= tcce_pkg::COLUMNS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tcce_pkg::REG_LAST_ROW: last_row_r <= cfg_wdata[LAST_ROW_W-1:0];
        tcce_pkg::REG_COLUMNS:  columns_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective geometry: bottom row and last column index
  always_comb begin
    lr = (int'(last_row_r) > MAX_ROWS - 1) ? ROW_W'(MAX_ROWS - 1) : ROW_W'(last_row_r);
    if (columns_r == '0) begin
      cols_m1 = '0;
    end else if (int'(columns_r) > MAX_COLS) begin
      cols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = COL_W'(columns_r - CFG_DATA_W'(1));
    end
  end

  tcce_front u_front (
    .in_ch    (in_ch),
    .can_push (can_push),
    .push     (push),
    .cmd      (push_cmd)
  );

  tcce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .can_push   (can_push),
    .head_valid (head_valid),
    .head       (head)
  );

  tcce_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .lr         (lr),
    .cols_m1    (cols_m1),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ sv/tcce_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_front
// Accepts command items and classifies them into engine operations.
// ----------------------------------------------------------------------------
module tcce_front (
  tcce_in_if.sink         in_ch,
  input  logic            can_push,
  output logic            push,
  output tcce_pkg::cmd_t  cmd
);

  assign in_ch.ready = can_push;
  assign push        = in_ch.valid && can_push;

  always_comb begin
    cmd.row  = in_ch.row;
    cmd.col  = in_ch.col;
    cmd.data = in_ch.char_code;
    case (in_ch.command)
      tcce_pkg::CMD_PUT_CHAR: begin
        case (in_ch.char_code)
          tcce_pkg::CH_CR:  cmd.op = tcce_pkg::OP_CR;
          tcce_pkg::CH_LF:  cmd.op = tcce_pkg::OP_LF;
          tcce_pkg::CH_TAB: cmd.op = tcce_pkg::OP_TAB;
          default:          cmd.op = tcce_pkg::OP_CHAR;
        endcase
      end
      tcce_pkg::CMD_SET_POS:   cmd.op = tcce_pkg::OP_SETPOS;
      tcce_pkg::CMD_SET_COLOR: begin
        cmd.op   = tcce_pkg::OP_COLOR;
        cmd.data = in_ch.color;
      end
      tcce_pkg::CMD_CLEAR:     cmd.op = tcce_pkg::OP_CLEAR;
      tcce_pkg::CMD_SCROLL:    cmd.op = tcce_pkg::OP_SCROLL;
      tcce_pkg::CMD_READ:      cmd.op = tcce_pkg::OP_READ;
      default:                 cmd.op = tcce_pkg::OP_NOP;
    endcase
  end

endmodule

@@ sv/tcce_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_queue
// Short command queue; the head stays in place while the back executes it.
// ----------------------------------------------------------------------------
module tcce_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcce_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            can_push,
  output logic            head_valid,
  output tcce_pkg::cmd_t  head
);

  localparam int QD    = tcce_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNT_W = $clog2(QD + 1);

  tcce_pkg::cmd_t   entry_r [QD];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign can_push   = rst_n && (cnt_r != CNT_W'(QD));
  assign head_valid = (cnt_r != '0);
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QD - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QD - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/tcce_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_back
// Command engine: cursor and attribute state, screen store, clear and
// scroll sweeps, and the result register.
// ----------------------------------------------------------------------------
module tcce_back #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 128,
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ROW_W-1:0] lr,
  input  logic [COL_W-1:0] cols_m1,
  input  logic             head_valid,
  input  tcce_pkg::cmd_t   head,
  output logic             pop,
  tcce_out_if.source       out_ch
);

  localparam int DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CELL_W    = tcce_pkg::CELL_W;
  localparam int BYTE_W    = tcce_pkg::BYTE_W;
  localparam int ROW_OUT_W = tcce_pkg::ROW_OUT_W;
  localparam int COL_OUT_W = tcce_pkg::COL_OUT_W;

  function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                              input logic [COL_W-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  tcce_pkg::state_t state_r, state_nxt;

  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [BYTE_W-1:0] attr_r, attr_nxt;
  logic [BYTE_W-1:0] prev_r, prev_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic [ROW_W-1:0]  sr_r, sr_nxt;
  logic [COL_W-1:0]  sc_r, sc_nxt;

  // one-deep write stage in front of the store
  logic              wr_en_r, wr_en_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic              wr_sel_rd_r, wr_sel_rd_nxt;
  logic [CELL_W-1:0] wr_val_r, wr_val_nxt;
  logic [CELL_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data_r;
  logic [CELL_W-1:0] screen_r [DEPTH];

  logic                 out_valid_r, out_valid_nxt;
  logic [ROW_OUT_W-1:0] out_row_r, out_row_nxt;
  logic [COL_OUT_W-1:0] out_col_r, out_col_nxt;
  logic [CELL_W-1:0]    out_cell_r, out_cell_nxt;
  logic [BYTE_W-1:0]    out_prev_r, out_prev_nxt;

  logic             dispatch;
  logic             out_free;
  logic [ROW_W-1:0] row_c, row_inc, req_row, sr_inc;
  logic [COL_W-1:0] col_c, req_col;
  logic             at_last_col, at_last_row, sc_last;
  logic [CELL_W-1:0] blank;

  assign dispatch    = (state_r == tcce_pkg::ST_IDLE) && head_valid;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign row_c       = (cur_row_r > lr) ? lr : cur_row_r;
  assign col_c       = (cur_col_r > cols_m1) ? cols_m1 : cur_col_r;
  assign row_inc     = row_c + ROW_W'(1);
  assign req_row     = (int'(head.row) > int'(lr)) ? lr : ROW_W'(head.row);
  assign req_col     = (int'(head.col) > int'(cols_m1)) ? cols_m1 : COL_W'(head.col);
  assign at_last_col = (col_c == cols_m1);
  assign at_last_row = (row_c == lr);
  assign sr_inc      = sr_r + ROW_W'(1);
  assign sc_last     = (sc_r == cols_m1);
  assign blank       = {attr_r, tcce_pkg::CH_BLANK};
  assign wr_data     = wr_sel_rd_r ? rd_data_r : wr_val_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcce_pkg::ST_IDLE: begin
        if (head_valid) begin
          case (head.op)
            tcce_pkg::OP_LF:
              state_nxt = at_last_row ? tcce_pkg::ST_SYNC : tcce_pkg::ST_RESP;
            tcce_pkg::OP_CHAR, tcce_pkg::OP_TAB:
              state_nxt = (at_last_col && at_last_row) ? tcce_pkg::ST_SYNC
                                                       : tcce_pkg::ST_RESP;
            tcce_pkg::OP_CLEAR:  state_nxt = tcce_pkg::ST_CLEAR;
            tcce_pkg::OP_SCROLL: state_nxt = tcce_pkg::ST_SYNC;
            tcce_pkg::OP_READ:   state_nxt = tcce_pkg::ST_READ;
            default:             state_nxt = tcce_pkg::ST_RESP;
          endcase
        end
      end
      tcce_pkg::ST_SYNC:
        state_nxt = (lr == '0) ? tcce_pkg::ST_BLANK : tcce_pkg::ST_SCROLL;
      tcce_pkg::ST_SCROLL:
        if (sc_last && (sr_inc == lr)) state_nxt = tcce_pkg::ST_BLANK;
      tcce_pkg::ST_BLANK:
        if (sc_last) state_nxt = tcce_pkg::ST_RESP;
      tcce_pkg::ST_CLEAR:
        if (sc_last && (sr_r == lr)) state_nxt = tcce_pkg::ST_RESP;
      tcce_pkg::ST_READ:
        state_nxt = tcce_pkg::ST_RESP;
      tcce_pkg::ST_RESP:
        if (out_free) state_nxt = tcce_pkg::ST_IDLE;
      default:
        state_nxt = tcce_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    attr_nxt      = attr_r;
    prev_nxt      = prev_r;
    cell_nxt      = cell_r;
    sr_nxt        = sr_r;
    sc_nxt        = sc_r;
    wr_en_nxt     = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    wr_sel_rd_nxt = 1'b0;
    wr_val_nxt    = wr_val_r;
    rd_addr       = cell_addr(sr_inc, sc_r);
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_cell_nxt  = out_cell_r;
    out_prev_nxt  = out_prev_r;

    case (state_r)
      tcce_pkg::ST_IDLE: begin
        if (dispatch) begin
          prev_nxt    = attr_r;
          cell_nxt    = '0;
          cur_row_nxt = row_c;
          cur_col_nxt = col_c;
          sr_nxt      = '0;
          sc_nxt      = '0;
          case (head.op)
            tcce_pkg::OP_CR: cur_col_nxt = '0;
            tcce_pkg::OP_LF: begin
              cur_col_nxt = '0;
              cur_row_nxt = at_last_row ? lr : row_inc;
            end
            tcce_pkg::OP_CHAR, tcce_pkg::OP_TAB: begin
              if (head.op == tcce_pkg::OP_CHAR) begin
                wr_en_nxt   = 1'b1;
                wr_addr_nxt = cell_addr(row_c, col_c);
                wr_val_nxt  = {attr_r, head.data};
              end
              if (at_last_col) begin
                cur_col_nxt = '0;
                cur_row_nxt = at_last_row ? lr : row_inc;
              end else begin
                cur_col_nxt = col_c + COL_W'(1);
              end
            end
            tcce_pkg::OP_SETPOS: begin
              cur_row_nxt = req_row;
              cur_col_nxt = req_col;
            end
            tcce_pkg::OP_COLOR: attr_nxt = head.data;
            tcce_pkg::OP_CLEAR: begin
              cur_row_nxt = '0;
              cur_col_nxt = '0;
            end
            tcce_pkg::OP_READ: rd_addr = cell_addr(req_row, req_col);
            default: ;
          endcase
        end
      end
      tcce_pkg::ST_SCROLL: begin
        // row sr+1 is read now and lands in row sr through the read register and the write stage
        wr_en_nxt     = 1'b1;
        wr_addr_nxt   = cell_addr(sr_r, sc_r);
        wr_sel_rd_nxt = 1'b1;
        if (sc_last) begin
          sc_nxt = '0;
          sr_nxt = sr_inc;
        end else begin
          sc_nxt = sc_r + COL_W'(1);
        end
      end
      tcce_pkg::ST_BLANK: begin
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = cell_addr(lr, sc_r);
        wr_val_nxt  = blank;
        sc_nxt      = sc_last ? '0 : sc_r + COL_W'(1);
      end
      tcce_pkg::ST_CLEAR: begin
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = cell_addr(sr_r, sc_r);
        wr_val_nxt  = blank;
        if (sc_last) begin
          sc_nxt = '0;
          sr_nxt = sr_inc;
        end else begin
          sc_nxt = sc_r + COL_W'(1);
        end
      end
      tcce_pkg::ST_READ: cell_nxt = rd_data_r;
      tcce_pkg::ST_RESP: begin
        if (out_free) begin
          pop           = 1'b1;
          out_valid_nxt = 1'b1;
          out_row_nxt   = ROW_OUT_W'(cur_row_r);
          out_col_nxt   = COL_OUT_W'(cur_col_r);
          out_cell_nxt  = cell_r;
          out_prev_nxt  = prev_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcce_pkg::ST_IDLE;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      attr_r      <= tcce_pkg::ATTR_RST;
      wr_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      attr_r      <= attr_nxt;
      wr_en_r     <= wr_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r      <= prev_nxt;
    cell_r      <= cell_nxt;
    sr_r        <= sr_nxt;
    sc_r        <= sc_nxt;
    wr_addr_r   <= wr_addr_nxt;
    wr_sel_rd_r <= wr_sel_rd_nxt;
    wr_val_r    <= wr_val_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_cell_r  <= out_cell_nxt;
    out_prev_r  <= out_prev_nxt;
  end

  // screen store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      screen_r[wr_addr_r] <= wr_data;
    end
    rd_data_r <= screen_r[rd_addr];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_row     = out_row_r;
  assign out_ch.cursor_col     = out_col_r;
  assign out_ch.cell_value     = out_cell_r;
  assign out_ch.previous_color = out_prev_r;

endmodule

@@ sv/tcce_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_port_checker
// Port-level checks of the console engine, bound to the top level.
// ----------------------------------------------------------------------------
module tcce_port_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tcce_pkg::ROW_OUT_W-1:0]    out_cursor_row,
  input logic [tcce_pkg::COL_OUT_W-1:0]    out_cursor_col,
  input logic [tcce_pkg::CELL_W-1:0]       out_cell_value,
  input logic [tcce_pkg::BYTE_W-1:0]       out_previous_color
);

  // items accepted whose result has not been taken yet
  logic [3:0] pend_r, pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      pend_nxt = pend_r + 4'd1;
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      pend_nxt = pend_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_row) &&
      $stable(out_cursor_col) && $stable(out_cell_value) && $stable(out_previous_color))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without an accepted item");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 4'd3 |-> !in_ready)
    else $error("item taken beyond queue and result capacity");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind text_console_cursor_engine_top tcce_port_checker u_tcce_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_cursor_row     (out_ch.cursor_row),
  .out_cursor_col     (out_ch.cursor_col),
  .out_cell_value     (out_ch.cell_value),
  .out_previous_color (out_ch.previous_color)
);
